### rtl/dlob_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dlob_pkg
// Shared types and constants for the depth limited order book.
// ----------------------------------------------------------------------------
package dlob_pkg;

  // number of price levels each side can hold
  localparam int BOOK_DEPTH = 16;
  // price field width (tick count)
  localparam int PRICE_W    = 32;
  // width of the stored level count, able to hold BOOK_DEPTH itself
  localparam int CNT_W      = $clog2(BOOK_DEPTH + 1);
  // fixed field widths of the ports
  localparam int LIMIT_W    = 5;
  localparam int COUNT_W    = 5;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(BOOK_DEPTH);

  // register index taken from the byte address
  localparam logic REG_DEPTH_LIMIT = 1'b0;

  // operation and side codes
  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_DEL = 1'b1;
  localparam logic SIDE_ASK = 1'b0;
  localparam logic SIDE_BID = 1'b1;

  // per cycle command broadcast to every cell of a side
  typedef struct packed {
    logic add_en;
    logic del_en;
  } cell_ctl_t;

endpackage
`default_nettype wire

### rtl/dlob_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dlob_cell
// One price level of a sorted side. Levels are kept best first as a key
// (descending); a cell takes the new key, its upper neighbor's key on an
// insert shift, or its lower neighbor's key on a delete shift.
// ----------------------------------------------------------------------------
module dlob_cell (
  input  wire logic                           clk_i,
  input  wire dlob_pkg::cell_ctl_t            ctl_i,
  input  wire logic [dlob_pkg::PRICE_W-1:0]   key_i,
  input  wire logic                           valid_i,
  input  wire logic                           up_gt_i,
  input  wire logic                           up_valid_i,
  input  wire logic [dlob_pkg::PRICE_W-1:0]   up_val_i,
  input  wire logic [dlob_pkg::PRICE_W-1:0]   dn_val_i,
  output logic                                gt_o,
  output logic                                hit_o,
  output logic [dlob_pkg::PRICE_W-1:0]        val_o,
  output logic [dlob_pkg::PRICE_W-1:0]        val_d_o
);

  logic [dlob_pkg::PRICE_W-1:0] val_q;
  logic [dlob_pkg::PRICE_W-1:0] val_d;
  logic                         ge;

  // an empty slot counts as worse than any key
  assign gt_o  = !valid_i || (key_i > val_q);
  assign ge    = valid_i && (key_i >= val_q);
  assign hit_o = valid_i && (key_i == val_q);

  always_comb begin
    val_d = val_q;
    if (ctl_i.add_en) begin
      if (gt_o && !up_gt_i) begin
        val_d = key_i;
      end else if (gt_o && up_gt_i && up_valid_i) begin
        val_d = up_val_i;
      end
    end else if (ctl_i.del_en) begin
      if (ge) begin
        val_d = dn_val_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o   = val_q;
  assign val_d_o = val_d;

endmodule
`default_nettype wire

### rtl/dlob_side.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dlob_side
// One side of the book: a chain of level cells sorted best first plus the
// level count. Inserts shift worse levels down, on a full side the worst one
// falls off the end; deletes shift the levels below the hit up.
// ----------------------------------------------------------------------------
module dlob_side (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  input  wire logic                           del_i,
  input  wire logic [dlob_pkg::PRICE_W-1:0]   key_i,
  input  wire logic [dlob_pkg::LIMIT_W-1:0]   limit_i,
  output logic [dlob_pkg::PRICE_W-1:0]        head_d_o,
  output logic [dlob_pkg::CNT_W-1:0]          count_d_o
);

  localparam int N = dlob_pkg::BOOK_DEPTH;

  logic [dlob_pkg::CNT_W-1:0]   count_q, count_d;
  logic [dlob_pkg::CNT_W-1:0]   lim;
  logic [N-1:0]                 valid, gt, hit;
  logic [dlob_pkg::PRICE_W-1:0] val_q [N];
  logic [dlob_pkg::PRICE_W-1:0] val_d [N];
  logic                         found;
  dlob_pkg::cell_ctl_t          ctl;

  // limit of zero acts as one, above the depth acts as the depth
  always_comb begin
    if (limit_i == '0) begin
      lim = dlob_pkg::CNT_W'(1);
    end else if (32'(limit_i) > N) begin
      lim = dlob_pkg::CNT_W'(N);
    end else begin
      lim = dlob_pkg::CNT_W'(limit_i);
    end
  end

  assign found      = |hit;
  assign ctl.add_en = en_i && (del_i == dlob_pkg::MODE_ADD) && !found;
  assign ctl.del_en = en_i && (del_i == dlob_pkg::MODE_DEL) && found;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                         up_gt, up_valid;
    logic [dlob_pkg::PRICE_W-1:0] up_val, dn_val;

    assign valid[i] = count_q > dlob_pkg::CNT_W'(i);

    if (i == 0) begin : g_head
      assign up_gt    = 1'b0;
      assign up_valid = 1'b1;
      assign up_val   = '0;
    end else begin : g_body
      assign up_gt    = gt[i-1];
      assign up_valid = valid[i-1];
      assign up_val   = val_q[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign dn_val = val_q[i];
    end else begin : g_mid
      assign dn_val = val_q[i+1];
    end

    dlob_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .key_i      (key_i),
      .valid_i    (valid[i]),
      .up_gt_i    (up_gt),
      .up_valid_i (up_valid),
      .up_val_i   (up_val),
      .dn_val_i   (dn_val),
      .gt_o       (gt[i]),
      .hit_o      (hit[i]),
      .val_o      (val_q[i]),
      .val_d_o    (val_d[i])
    );
  end

  // a full side keeps its count: the insert pushes the worst level out
  always_comb begin
    count_d = count_q;
    if (ctl.add_en && (count_q < lim)) begin
      count_d = count_q + dlob_pkg::CNT_W'(1);
    end else if (ctl.del_en) begin
      count_d = count_q - dlob_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign head_d_o  = val_d[0];
  assign count_d_o = count_d;

endmodule
`default_nettype wire

### rtl/depth_limited_order_book_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// depth_limited_order_book_top
// Price level book with a bid side and an ask side of limited depth.
// ----------------------------------------------------------------------------
// Each accepted word (add or delete of one price on one side) is applied in
// the cycle it is taken and its result word (best bid, best ask, valid flags
// and level counts after the update) is offered on the next cycle from an
// output register. One word per cycle is sustained as long as the output side
// takes results; the input stalls only while a result waits unread. Each
// side is a chain of 16 sorted level cells that all update in the same cycle,
// so the rate does not depend on book fill. Asks are held as inverted keys so
// both chains sort the same way. depth_limit is written over the APB port at
// byte address 0 and resets to 16.
module depth_limited_order_book_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [dlob_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [dlob_pkg::PDATA_W-1:0]   pwdata,
  output logic [dlob_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready,
  // input words
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           mode_i,
  input  wire logic                           side_i,
  input  wire logic [dlob_pkg::PRICE_W-1:0]   price_i,
  // result words
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [dlob_pkg::PRICE_W-1:0]        best_bid_o,
  output logic                                bid_valid_o,
  output logic [dlob_pkg::PRICE_W-1:0]        best_ask_o,
  output logic                                ask_valid_o,
  output logic [dlob_pkg::COUNT_W-1:0]        bid_count_o,
  output logic [dlob_pkg::COUNT_W-1:0]        ask_count_o
);

  logic [dlob_pkg::LIMIT_W-1:0] limit_q;
  logic                         cfg_wr;
  logic                         accept;
  logic [dlob_pkg::PRICE_W-1:0] key;
  logic [dlob_pkg::PRICE_W-1:0] bid_head_d, ask_head_d;
  logic [dlob_pkg::CNT_W-1:0]   bid_cnt_d, ask_cnt_d;

  logic                         out_valid_q;
  logic [dlob_pkg::PRICE_W-1:0] best_bid_q, best_ask_q;
  logic [dlob_pkg::COUNT_W-1:0] bid_count_q, ask_count_q;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == dlob_pkg::REG_DEPTH_LIMIT);
  assign prdata = (paddr[2] == dlob_pkg::REG_DEPTH_LIMIT) ?
                  dlob_pkg::PDATA_W'(limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= dlob_pkg::LIMIT_RESET;
    end else if (cfg_wr) begin
      limit_q <= pwdata[dlob_pkg::LIMIT_W-1:0];
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // asks inverted so the lowest ask sorts first
  assign key = (side_i == dlob_pkg::SIDE_BID) ? price_i : ~price_i;

  dlob_side u_bid (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (accept && (side_i == dlob_pkg::SIDE_BID)),
    .del_i     (mode_i),
    .key_i     (key),
    .limit_i   (limit_q),
    .head_d_o  (bid_head_d),
    .count_d_o (bid_cnt_d)
  );

  dlob_side u_ask (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (accept && (side_i == dlob_pkg::SIDE_ASK)),
    .del_i     (mode_i),
    .key_i     (key),
    .limit_i   (limit_q),
    .head_d_o  (ask_head_d),
    .count_d_o (ask_cnt_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      best_bid_q  <= (bid_cnt_d != '0) ? bid_head_d : '0;
      best_ask_q  <= (ask_cnt_d != '0) ? ~ask_head_d : '0;
      bid_count_q <= dlob_pkg::COUNT_W'(bid_cnt_d);
      ask_count_q <= dlob_pkg::COUNT_W'(ask_cnt_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign best_bid_o  = best_bid_q;
  assign best_ask_o  = best_ask_q;
  assign bid_count_o = bid_count_q;
  assign ask_count_o = ask_count_q;
  assign bid_valid_o = (bid_count_q != '0);
  assign ask_valid_o = (ask_count_q != '0);

  a_bid_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(bid_count_o) <= dlob_pkg::BOOK_DEPTH))
    else $error("bid level count above book depth");

  a_ask_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(ask_count_o) <= dlob_pkg::BOOK_DEPTH))
    else $error("ask level count above book depth");

  a_empty_bid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !bid_valid_o) |-> (best_bid_o == '0))
    else $error("best bid not zero on empty bid side");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a pending result");

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the depth limited order book. A directed table
// covers extreme prices, duplicates, absent deletes, full sides and out of
// range depth limits. Random add and delete words follow over several depth
// settings. Each result word is checked against a behavioral price book or a typed row's view.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    logic [dlob_pkg::PRICE_W-1:0] best_bid;
    logic                         bid_valid;
    logic [dlob_pkg::PRICE_W-1:0] best_ask;
    logic                         ask_valid;
    logic [dlob_pkg::COUNT_W-1:0] bid_count;
    logic [dlob_pkg::COUNT_W-1:0] ask_count;
  } book_view_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_LIMIT} row_kind_e;

  typedef struct packed {
    row_kind_e                    kind;
    logic                         mode;
    logic                         side;
    // holds the new depth limit on ROW_LIMIT rows
    logic [dlob_pkg::PRICE_W-1:0] price;
    book_view_t                   view;
  } dir_row_t;

  localparam logic [dlob_pkg::PRICE_W-1:0] P_MAX = '1;
  localparam int N_ROWS      = 28;
  localparam int N_PHASES    = 9;
  localparam int PHASE_WORDS = 45;
  localparam int POOL_N      = 24;
  localparam int WDOG_LIMIT  = 2000;

  dir_row_t dir_rows [N_ROWS] = '{
    '{ROW_TYPED,   dlob_pkg::MODE_ADD, dlob_pkg::SIDE_BID, 32'd100,
      '{32'd100, 1'b1, 32'd0, 1'b0, 5'd1, 5'd0}},
    '{ROW_TYPED,   dlob_pkg::MODE_ADD, dlob_pkg::SIDE_ASK, 32'd200,
      '{32'd100, 1'b1, 32'd200, 1'b1, 5'd1, 5'd1}},
    '{ROW_TYPED,   dlob_pkg::MODE_ADD, dlob_pkg::SIDE_BID, P_MAX,
      '{P_MAX, 1'b1, 32'd200, 1'b1, 5'd2, 5'd1}},
    // ask at price zero is still a valid ask
    '{ROW_TYPED,   dlob_pkg::MODE_ADD, dlob_pkg::SIDE_ASK, 32'd0,
      '{P_MAX, 1'b1, 32'd0, 1'b1, 5'd2, 5'd2}},
    '{ROW_TYPED,   dlob_pkg::MODE_ADD, dlob_pkg::SIDE_BID, 32'd0,
      '{P_MAX, 1'b1, 32'd0, 1'b1, 5'd3, 5'd2}},
    // duplicate add leaves the book alone
    '{ROW_TYPED,   dlob_pkg::MODE_ADD, dlob_pkg::SIDE_BID, 32'd100,
      '{P_MAX, 1'b1, 32'd0, 1'b1, 5'd3, 5'd2}},
    '{ROW_TYPED,   dlob_pkg::MODE_ADD, dlob_pkg::SIDE_ASK, P_MAX,
      '{P_MAX, 1'b1, 32'd0, 1'b1, 5'd3, 5'd3}},
    // delete of a price that is not there
    '{ROW_TYPED,   dlob_pkg::MODE_DEL, dlob_pkg::SIDE_ASK, 32'd12345,
      '{P_MAX, 1'b1, 32'd0, 1'b1, 5'd3, 5'd3}},
    '{ROW_TYPED,   dlob_pkg::MODE_DEL, dlob_pkg::SIDE_BID, P_MAX,
      '{32'd100, 1'b1, 32'd0, 1'b1, 5'd2, 5'd3}},
    '{ROW_TYPED,   dlob_pkg::MODE_DEL, dlob_pkg::SIDE_ASK, 32'd0,
      '{32'd100, 1'b1, 32'd200, 1'b1, 5'd2, 5'd2}},
    // both sides full at depth 2: better adds evict, worse ones drop
    '{ROW_LIMIT,   dlob_pkg::MODE_ADD, dlob_pkg::SIDE_ASK, 32'd2,     '0},
    '{ROW_PREDICT, dlob_pkg::MODE_ADD, dlob_pkg::SIDE_BID, 32'd50,    '0},
    '{ROW_PREDICT, dlob_pkg::MODE_ADD, dlob_pkg::SIDE_BID, 32'd10,    '0},
    '{ROW_PREDICT, dlob_pkg::MODE_ADD, dlob_pkg::SIDE_ASK, 32'd150,   '0},
    '{ROW_PREDICT, dlob_pkg::MODE_ADD, dlob_pkg::SIDE_ASK, 32'd300,   '0},
    // limit below the stored count keeps the levels
    '{ROW_LIMIT,   dlob_pkg::MODE_ADD, dlob_pkg::SIDE_ASK, 32'd1,     '0},
    '{ROW_PREDICT, dlob_pkg::MODE_ADD, dlob_pkg::SIDE_BID, 32'd200,   '0},
    '{ROW_PREDICT, dlob_pkg::MODE_ADD, dlob_pkg::SIDE_ASK, 32'd100,   '0},
    // zero limit behaves as one
    '{ROW_LIMIT,   dlob_pkg::MODE_ADD, dlob_pkg::SIDE_ASK, 32'd0,     '0},
    '{ROW_PREDICT, dlob_pkg::MODE_ADD, dlob_pkg::SIDE_BID, 32'd300,   '0},
    '{ROW_PREDICT, dlob_pkg::MODE_DEL, dlob_pkg::SIDE_BID, 32'd300,   '0},
    '{ROW_PREDICT, dlob_pkg::MODE_ADD, dlob_pkg::SIDE_BID, 32'd400,   '0},
    // limit above the book depth saturates
    '{ROW_LIMIT,   dlob_pkg::MODE_ADD, dlob_pkg::SIDE_ASK, 32'd31,    '0},
    '{ROW_PREDICT, dlob_pkg::MODE_ADD, dlob_pkg::SIDE_BID, 32'd1,     '0},
    '{ROW_PREDICT, dlob_pkg::MODE_DEL, dlob_pkg::SIDE_ASK, 32'd100,   '0},
    '{ROW_TYPED,   dlob_pkg::MODE_DEL, dlob_pkg::SIDE_ASK, 32'd150,
      '{32'd400, 1'b1, 32'd0, 1'b0, 5'd2, 5'd0}},
    '{ROW_PREDICT, dlob_pkg::MODE_DEL, dlob_pkg::SIDE_BID, 32'd400,   '0},
    '{ROW_TYPED,   dlob_pkg::MODE_DEL, dlob_pkg::SIDE_BID, 32'd1,
      '{32'd0, 1'b0, 32'd0, 1'b0, 5'd0, 5'd0}}
  };

  logic [dlob_pkg::LIMIT_W-1:0] phase_limits [N_PHASES] = '{
    5'd16, 5'd2, 5'd1, 5'd0, 5'd9, 5'd31, 5'd17, 5'd5, 5'd16
  };

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [dlob_pkg::PADDR_W-1:0]  paddr = '0;
  logic [dlob_pkg::PDATA_W-1:0]  pwdata = '0;
  logic [dlob_pkg::PDATA_W-1:0]  prdata;
  logic                          pready;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic                          mode_i = dlob_pkg::MODE_ADD;
  logic                          side_i = dlob_pkg::SIDE_ASK;
  logic [dlob_pkg::PRICE_W-1:0]  price_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [dlob_pkg::PRICE_W-1:0]  best_bid_o;
  logic                          bid_valid_o;
  logic [dlob_pkg::PRICE_W-1:0]  best_ask_o;
  logic                          ask_valid_o;
  logic [dlob_pkg::COUNT_W-1:0]  bid_count_o;
  logic [dlob_pkg::COUNT_W-1:0]  ask_count_o;

  // behavioral book: one row of levels per side, indexed by the side code
  logic [dlob_pkg::PRICE_W-1:0]  levels [2][dlob_pkg::BOOK_DEPTH];
  int                            level_cnt [2] = '{0, 0};
  logic [dlob_pkg::LIMIT_W-1:0]  depth_cfg = dlob_pkg::LIMIT_RESET;

  book_view_t                    view_q [$];
  book_view_t                    head_view;
  logic [dlob_pkg::PRICE_W-1:0]  price_pool [POOL_N];
  int                            fail_cnt = 0;
  int                            words_sent = 0;
  int                            results_seen = 0;
  int                            limit_writes = 0;
  int                            stall_left = 0;
  int                            quiet_cycles = 0;
  bit                            sender_idle = 1'b1;
  bit                            rx_calm = 1'b0;

  depth_limited_order_book_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .side_i      (side_i),
    .price_i     (price_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .best_bid_o  (best_bid_o),
    .bid_valid_o (bid_valid_o),
    .best_ask_o  (best_ask_o),
    .ask_valid_o (ask_valid_o),
    .bid_count_o (bid_count_o),
    .ask_count_o (ask_count_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // applies one order to the book and returns the top of book after it
  function automatic book_view_t apply_order(input logic m, input logic s,
                                             input logic [dlob_pkg::PRICE_W-1:0] p);
    int i, hit, worst, cap;
    book_view_t v;
    cap = (depth_cfg == 0) ? 1 :
          ((depth_cfg > dlob_pkg::BOOK_DEPTH) ? dlob_pkg::BOOK_DEPTH : int'(depth_cfg));
    hit = -1;
    for (i = 0; i < level_cnt[s]; i++)
      if (levels[s][i] == p) hit = i;
    if (m == dlob_pkg::MODE_ADD) begin
      if (hit < 0) begin
        if (level_cnt[s] < cap) begin
          levels[s][level_cnt[s]] = p;
          level_cnt[s]++;
        end else begin
          // worst level: lowest bid or highest ask
          worst = 0;
          for (i = 1; i < level_cnt[s]; i++)
            if ((s == dlob_pkg::SIDE_BID) ? (levels[s][i] < levels[s][worst])
                                          : (levels[s][i] > levels[s][worst])) worst = i;
          if ((s == dlob_pkg::SIDE_BID) ? (p > levels[s][worst]) : (p < levels[s][worst]))
            levels[s][worst] = p;
        end
      end
    end else if (hit >= 0) begin
      level_cnt[s]--;
      levels[s][hit] = levels[s][level_cnt[s]];
    end
    v = '0;
    if (level_cnt[dlob_pkg::SIDE_BID] > 0) begin
      v.bid_valid = 1'b1;
      v.best_bid = levels[dlob_pkg::SIDE_BID][0];
      for (i = 1; i < level_cnt[dlob_pkg::SIDE_BID]; i++)
        if (levels[dlob_pkg::SIDE_BID][i] > v.best_bid)
          v.best_bid = levels[dlob_pkg::SIDE_BID][i];
    end
    if (level_cnt[dlob_pkg::SIDE_ASK] > 0) begin
      v.ask_valid = 1'b1;
      v.best_ask = levels[dlob_pkg::SIDE_ASK][0];
      for (i = 1; i < level_cnt[dlob_pkg::SIDE_ASK]; i++)
        if (levels[dlob_pkg::SIDE_ASK][i] < v.best_ask)
          v.best_ask = levels[dlob_pkg::SIDE_ASK][i];
    end
    v.bid_count = dlob_pkg::COUNT_W'(level_cnt[dlob_pkg::SIDE_BID]);
    v.ask_count = dlob_pkg::COUNT_W'(level_cnt[dlob_pkg::SIDE_ASK]);
    return v;
  endfunction

  task automatic send_word(input logic m, input logic s,
                           input logic [dlob_pkg::PRICE_W-1:0] p,
                           input bit typed, input book_view_t typed_view);
    book_view_t pv;
    if (sender_idle && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= m;
    side_i     <= s;
    price_i    <= p;
    do @(posedge clk_i); while (!in_ready_o);
    pv = apply_order(m, s, p);
    view_q.push_back(typed ? typed_view : pv);
    words_sent++;
  endtask

  // depth limit is only changed once every pending result word has been checked
  task automatic set_limit(input logic [dlob_pkg::LIMIT_W-1:0] lim);
    in_valid_i <= 1'b0;
    while (view_q.size() != 0) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= dlob_pkg::PADDR_W'({dlob_pkg::REG_DEPTH_LIMIT, 2'b00});
    pwdata  <= dlob_pkg::PDATA_W'(lim);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    depth_cfg = lim;
    limit_writes++;
  endtask

  task automatic random_word();
    logic m, s;
    logic [dlob_pkg::PRICE_W-1:0] p;
    int pick;
    m = ($urandom_range(0, 99) < 62) ? dlob_pkg::MODE_ADD : dlob_pkg::MODE_DEL;
    s = $urandom_range(0, 1) ? dlob_pkg::SIDE_BID : dlob_pkg::SIDE_ASK;
    pick = $urandom_range(0, 99);
    if (m == dlob_pkg::MODE_DEL && level_cnt[s] > 0 && pick < 70)
      p = levels[s][$urandom_range(0, level_cnt[s] - 1)];
    else if (pick < 85)
      p = price_pool[$urandom_range(0, POOL_N - 1)];
    else if (pick < 91)
      p = $urandom_range(0, 1) ? P_MAX : '0;
    else
      p = $urandom();
    send_word(m, s, p, 1'b0, '0);
  endtask

  task automatic check_field(input string name,
                             input logic [dlob_pkg::PRICE_W-1:0] want,
                             input logic [dlob_pkg::PRICE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endtask

  // result side stalls in bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (!rx_calm && $urandom_range(0, 9) == 0) begin
      stall_left  <= $urandom_range(0, 13);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (view_q.size() == 0) begin
        $error("result word with no order pending");
        fail_cnt++;
      end else begin
        head_view = view_q.pop_front();
        check_field("best_bid", head_view.best_bid, best_bid_o);
        check_field("bid_valid", dlob_pkg::PRICE_W'(head_view.bid_valid),
                    dlob_pkg::PRICE_W'(bid_valid_o));
        check_field("best_ask", head_view.best_ask, best_ask_o);
        check_field("ask_valid", dlob_pkg::PRICE_W'(head_view.ask_valid),
                    dlob_pkg::PRICE_W'(ask_valid_o));
        check_field("bid_count", dlob_pkg::PRICE_W'(head_view.bid_count),
                    dlob_pkg::PRICE_W'(bid_count_o));
        check_field("ask_count", dlob_pkg::PRICE_W'(head_view.ask_count),
                    dlob_pkg::PRICE_W'(ask_count_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("no handshake for %0d cycles", WDOG_LIMIT);
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    int ph, k;
    for (k = 0; k < POOL_N; k++) price_pool[k] = $urandom();
    price_pool[0] = '0;
    price_pool[1] = P_MAX;
    for (k = 2; k < 8; k++) price_pool[k] = dlob_pkg::PRICE_W'($urandom_range(1, 40));
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_LIMIT)
        set_limit(dir_rows[r].price[dlob_pkg::LIMIT_W-1:0]);
      else
        send_word(dir_rows[r].mode, dir_rows[r].side, dir_rows[r].price,
                  dir_rows[r].kind == ROW_TYPED, dir_rows[r].view);
    end

    for (ph = 0; ph < N_PHASES; ph++) begin
      // last phase runs at full rate on both sides
      rx_calm     = (ph == N_PHASES - 1);
      sender_idle = (ph % 3 != 2) && !rx_calm;
      set_limit(phase_limits[ph]);
      for (k = 0; k < PHASE_WORDS; k++) random_word();
    end
    in_valid_i <= 1'b0;

    while (view_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("%0d order words sent, %0d result words checked", words_sent, results_seen);
    $display("%0d depth limit writes, values from 0 to 31", limit_writes);
    if (fail_cnt == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/dlob_pkg.sv
rtl/dlob_cell.sv
rtl/dlob_side.sv
rtl/depth_limited_order_book_top.sv
tb/sv/tb_top.sv
